// ----- src/lts_pkg.sv -----
// shared types, codes and defaults of the lottery task scheduler
package lts_pkg;

   localparam int MAX_TASKS_DEF   = 16;
   localparam int TICKET_BITS_DEF = 16;

   localparam int CMD_W        = 2;
   localparam int TICKET_FIELD_W = 16;
   localparam int RAND_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int ID_W         = 16;
   localparam int TASK_COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHOOSE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_TASK = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_CUR  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [TICKET_FIELD_W-1:0] ticket_count;
      logic [RAND_W-1:0]         random_word;
   } lts_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [ID_W-1:0]         task_id;
      logic                    first_run;
      logic [TASK_COUNT_W-1:0] task_count;
   } lts_rsp_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SUM  = 6'b000010,
      S_MOD  = 6'b000100,
      S_WALK = 6'b001000,
      S_EXIT = 6'b010000,
      S_RESP = 6'b100000
   } lts_state_type;

endpackage

// ----- src/lts_task_mem.sv -----
// task table memory: one read port and one write port, registered read data
module lts_task_mem #(
   parameter int DEPTH = lts_pkg::MAX_TASKS_DEF,
   parameter int WIDTH = 33,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/lts_mod_unit.sv -----
// bit-serial remainder unit: 32-bit dividend modulo a ticket total
module lts_mod_unit #(
   parameter int DW = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lts_pkg::RAND_W-1:0]  dividend,
   input  logic [DW-1:0]               divisor,
   output logic                        done,
   output logic [DW-1:0]               remainder
);

   localparam int NW = lts_pkg::RAND_W;
   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW:0]     shifted;
   logic [DW:0]     diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], 1'b0};
         rem_in = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/lottery_task_scheduler_core.sv -----
// lottery task scheduler: task table, sequencer and response register
//
// Usage: one request channel (req_valid, req_stall, req_data) carries a
// command: create a task with a ticket count, choose the next task by lottery
// using req_data.random_word, or exit the current task. Every request yields
// exactly one transaction on the response channel (rsp_valid, rsp_stall,
// rsp_data) with status, task id, first-run flag and the task count after
// the command. A transaction moves when valid is high and stall is low.
// Requests are handled one at a time; req_stall is low only while idle.
// Steps from request to response:
//   create or no-op: straight to the response state
//   exit: reads from the current task on, shift writes
//   choose: a pass over the table summing tickets, the bit-serial remainder
//   unit, then a pass to find the winner
// The table lives in one memory with one read and one write port; the
// sequential passes over that memory and the remainder unit set the rate.
// A finished response waits in the output register while rsp_stall is high;
// the sequencer holds the next result until that register is free.
// Reset (synchronous, active high) empties the table and clears the id counter
// and the current task; memory contents are left as they are.
module lottery_task_scheduler_core #(
   parameter int MAX_TASKS   = lts_pkg::MAX_TASKS_DEF,
   parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lts_pkg::lts_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lts_pkg::lts_rsp_type rsp_data
);

   localparam int FW  = lts_pkg::TICKET_FIELD_W;
   localparam int SW  = (TICKET_BITS < FW) ? TICKET_BITS : FW;
   localparam int IDW = lts_pkg::ID_W;
   localparam int IW  = $clog2(MAX_TASKS);
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int TW  = SW + IW;
   localparam int EW  = SW + IDW + 1;
   localparam int TCW = lts_pkg::TASK_COUNT_W;

   lts_pkg::lts_state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  addr_ff, addr_in;
   logic [IW-1:0]  didx_ff, didx_in;
   logic           pend_ff, pend_in;
   logic [IW-1:0]  cur_slot_ff, cur_slot_in;
   logic           cur_valid_ff, cur_valid_in;
   logic [IDW-1:0] next_id_ff, next_id_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0]  total_ff, total_in;
   logic [TW-1:0]  rem_ff, rem_in;
   logic [lts_pkg::RAND_W-1:0] rand_ff, rand_in;
   logic [lts_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDW-1:0] res_id_ff, res_id_in;
   logic           res_first_ff, res_first_in;
   lts_pkg::lts_rsp_type rsp_data_ff, rsp_data_in;

   logic           issue;
   logic           rsp_load;
   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   logic [EW-1:0]  wr_data;
   logic [EW-1:0]  rd_data;
   logic [SW-1:0]  rd_ticket;
   logic [IDW-1:0] rd_id;
   logic           rd_started;
   logic [TW-1:0]  run_next;
   logic           hit;
   logic           div_start;
   logic           div_done;
   logic [TW-1:0]  div_rem;

   lts_task_mem #(
      .DEPTH (MAX_TASKS),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (issue),
      .rd_addr (addr_ff[IW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lts_mod_unit #(
      .DW (TW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rand_ff),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rd_ticket  = rd_data[EW-1 -: SW];
   assign rd_id      = rd_data[IDW:1];
   assign rd_started = rd_data[0];
   assign run_next   = total_ff + TW'(rd_ticket);
   assign hit        = pend_ff && (rem_ff < run_next);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      didx_in       = didx_ff;
      cur_slot_in   = cur_slot_ff;
      cur_valid_in  = cur_valid_ff;
      next_id_in    = next_id_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      rand_in       = rand_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_first_in  = res_first_ff;
      issue         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         lts_pkg::S_IDLE: begin
            if (req_valid) begin
               res_status_in = lts_pkg::ST_OK;
               res_id_in     = '0;
               res_first_in  = 1'b0;
               rand_in       = req_data.random_word;
               addr_in       = '0;
               total_in      = '0;
               state_in      = lts_pkg::S_RESP;
               unique case (req_data.command)
                  lts_pkg::CMD_CREATE: begin
                     if (count_ff >= CW'(MAX_TASKS)) begin
                        res_status_in = lts_pkg::ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[IW-1:0];
                        wr_data    = {SW'(req_data.ticket_count), next_id_ff, 1'b0};
                        res_id_in  = next_id_ff;
                        next_id_in = next_id_ff + IDW'(1);
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  lts_pkg::CMD_CHOOSE: begin
                     if (count_ff == '0) begin
                        res_status_in = lts_pkg::ST_NO_TASK;
                     end else begin
                        state_in = lts_pkg::S_SUM;
                     end
                  end
                  lts_pkg::CMD_EXIT: begin
                     if (!cur_valid_ff || (CW'(cur_slot_ff) >= count_ff)) begin
                        res_status_in = lts_pkg::ST_NO_CUR;
                     end else begin
                        addr_in  = CW'(cur_slot_ff);
                        state_in = lts_pkg::S_EXIT;
                     end
                  end
                  lts_pkg::CMD_NOP: begin
                     res_status_in = lts_pkg::ST_OK;
                  end
                  default: begin
                     res_status_in = lts_pkg::ST_OK;
                  end
               endcase
            end
         end
         lts_pkg::S_SUM: begin
            if (pend_ff) begin
               total_in = run_next;
            end
            if (addr_ff < count_ff) begin
               issue = 1'b1;
            end else if (!pend_ff) begin
               if (total_ff == '0) begin
                  res_status_in = lts_pkg::ST_NO_TASK;
                  state_in      = lts_pkg::S_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = lts_pkg::S_MOD;
               end
            end
         end
         lts_pkg::S_MOD: begin
            if (div_done) begin
               rem_in   = div_rem;
               total_in = '0;
               addr_in  = '0;
               state_in = lts_pkg::S_WALK;
            end
         end
         lts_pkg::S_WALK: begin
            if (pend_ff) begin
               total_in = run_next;
            end
            if (hit) begin
               wr_en        = 1'b1;
               wr_addr      = didx_ff;
               wr_data      = {rd_ticket, rd_id, 1'b1};
               res_id_in    = rd_id;
               res_first_in = !rd_started;
               cur_slot_in  = didx_ff;
               cur_valid_in = 1'b1;
               state_in     = lts_pkg::S_RESP;
            end else if (addr_ff < count_ff) begin
               issue = 1'b1;
            end
         end
         lts_pkg::S_EXIT: begin
            if (pend_ff) begin
               if (didx_ff == cur_slot_ff) begin
                  res_id_in = rd_id;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = didx_ff - IW'(1);
                  wr_data = rd_data;
               end
            end
            if (addr_ff < count_ff) begin
               issue = 1'b1;
            end else if (!pend_ff) begin
               count_in     = count_ff - CW'(1);
               cur_valid_in = 1'b0;
               state_in     = lts_pkg::S_RESP;
            end
         end
         lts_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = lts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lts_pkg::S_IDLE;
         end
      endcase

      if (issue) begin
         addr_in = addr_ff + CW'(1);
         didx_in = addr_ff[IW-1:0];
      end
      pend_in = issue;

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.status     = res_status_ff;
         rsp_data_in.task_id    = res_id_ff;
         rsp_data_in.first_run  = res_first_ff;
         rsp_data_in.task_count = TCW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lts_pkg::S_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff       <= didx_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      rand_ff       <= rand_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_first_ff  <= res_first_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != lts_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count beyond table depth");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (CW'(cur_slot_ff) < count_ff))
      else $error("current task outside the table");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lts_pkg::S_RESP))
      else $error("response raised outside the response state");

   a_div_in_mod: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lts_pkg::S_MOD))
      else $error("remainder finished outside the modulo state");

   a_win_current: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lts_pkg::S_WALK && hit) |=> (cur_valid_ff && $stable(count_ff)))
      else $error("winner not made current");
`endif

endmodule
